// ===== rtl/assert_macros.svh =====
// assertion macros shared by the deframer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define SWFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked at the same edge
`define SWFD_ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// implication checked at the next edge
`define SWFD_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/swfd_pkg.sv =====
// shared types and constants of the sync word frame deframer
package swfd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned WORD_W  = 16;
   localparam int unsigned PHASE_W = 2;
   localparam int unsigned HDR_W   = 2;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [PHASE_W-1:0] PH_SYNC0   = 2'd0;
   localparam logic [PHASE_W-1:0] PH_SYNC1   = 2'd1;
   localparam logic [PHASE_W-1:0] PH_HEADER  = 2'd2;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd3;

   localparam logic [HDR_W-1:0] HDR_CHAN_LO = 2'd0;
   localparam logic [HDR_W-1:0] HDR_CHAN_HI = 2'd1;
   localparam logic [HDR_W-1:0] HDR_LEN_LO  = 2'd2;
   localparam logic [HDR_W-1:0] HDR_LEN_HI  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD = 2'd2;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h5A;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'hA5;
   localparam logic [WORD_W-1:0] MAX_PAYLOAD_RST = 16'd1024;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_EMPTY   = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_first;
      logic [BYTE_W-1:0] sync_second;
      logic [WORD_W-1:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic              kind;
      logic [WORD_W-1:0] channel;
      logic [BYTE_W-1:0] payload_byte;
      logic              frame_last;
   } result_type;

endpackage

// ===== rtl/swfd_parser.sv =====
// sync hunt, header gather and payload count for one byte per cycle while byte_valid is high
`include "assert_macros.svh"

module swfd_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  swfd_pkg::cfg_type            cfg,
   input  logic                         byte_valid,
   input  logic [swfd_pkg::BYTE_W-1:0]  byte_data,
   output logic                         res_valid,
   output swfd_pkg::result_type         res
);

   logic [swfd_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [swfd_pkg::HDR_W-1:0]   hdr_idx_ff, hdr_idx_in;
   logic [swfd_pkg::WORD_W-1:0]  chan_ff, chan_in;
   logic [swfd_pkg::WORD_W-1:0]  len_ff, len_in;
   logic [swfd_pkg::WORD_W-1:0]  count_ff, count_in;
   logic [swfd_pkg::WORD_W-1:0]  len_full;
   logic [swfd_pkg::WORD_W:0]    count_next;
   logic                         count_last;

   assign len_full   = {byte_data, len_ff[swfd_pkg::BYTE_W-1:0]};
   assign count_next = {1'b0, count_ff} + {{swfd_pkg::WORD_W{1'b0}}, 1'b1};
   assign count_last = count_next >= {1'b0, len_ff};

   always_comb begin
      phase_in   = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      chan_in    = chan_ff;
      len_in     = len_ff;
      count_in   = count_ff;
      res_valid  = 1'b0;
      res.kind         = swfd_pkg::KIND_PAYLOAD;
      res.channel      = chan_ff;
      res.payload_byte = byte_data;
      res.frame_last   = 1'b0;
      if (byte_valid) begin
         unique case (phase_ff)
            swfd_pkg::PH_SYNC0: begin
               if (byte_data == cfg.sync_first) begin
                  phase_in = swfd_pkg::PH_SYNC1;
               end
            end
            swfd_pkg::PH_SYNC1: begin
               if (byte_data == cfg.sync_second) begin
                  hdr_idx_in = swfd_pkg::HDR_CHAN_LO;
                  phase_in   = swfd_pkg::PH_HEADER;
               end else if (byte_data != cfg.sync_first) begin
                  phase_in = swfd_pkg::PH_SYNC0;
               end
            end
            swfd_pkg::PH_HEADER: begin
               hdr_idx_in = hdr_idx_ff + 2'd1;
               case (hdr_idx_ff)
                  swfd_pkg::HDR_CHAN_LO: begin
                     chan_in = {chan_ff[swfd_pkg::WORD_W-1:swfd_pkg::BYTE_W], byte_data};
                  end
                  swfd_pkg::HDR_CHAN_HI: begin
                     chan_in = {byte_data, chan_ff[swfd_pkg::BYTE_W-1:0]};
                  end
                  swfd_pkg::HDR_LEN_LO: begin
                     len_in = {len_ff[swfd_pkg::WORD_W-1:swfd_pkg::BYTE_W], byte_data};
                  end
                  default: begin
                     len_in = len_full;
                     if (len_full == '0) begin
                        phase_in         = swfd_pkg::PH_SYNC0;
                        res_valid        = 1'b1;
                        res.kind         = swfd_pkg::KIND_EMPTY;
                        res.payload_byte = '0;
                        res.frame_last   = 1'b1;
                     end else if (len_full > cfg.max_payload) begin
                        phase_in = swfd_pkg::PH_SYNC0;
                     end else begin
                        count_in = '0;
                        phase_in = swfd_pkg::PH_PAYLOAD;
                     end
                  end
               endcase
            end
            swfd_pkg::PH_PAYLOAD: begin
               count_in       = count_next[swfd_pkg::WORD_W-1:0];
               res_valid      = 1'b1;
               res.frame_last = count_last;
               if (count_last) begin
                  phase_in = swfd_pkg::PH_SYNC0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= swfd_pkg::PH_SYNC0;
         hdr_idx_ff <= '0;
         chan_ff    <= '0;
         len_ff     <= '0;
         count_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         chan_ff    <= chan_in;
         len_ff     <= len_in;
         count_ff   <= count_in;
      end
   end

   `SWFD_ASSERT_NEXT(a_last_ends_frame, res_valid && res.frame_last,
      phase_ff == swfd_pkg::PH_SYNC0, "frame end did not return to sync hunt")
   `SWFD_ASSERT_IMPL(a_empty_is_last, res_valid && res.kind == swfd_pkg::KIND_EMPTY,
      res.frame_last && res.payload_byte == '0, "empty frame result malformed")
   `SWFD_ASSERT_IMPL(a_count_below_len, phase_ff == swfd_pkg::PH_PAYLOAD,
      count_ff < len_ff, "payload count reached length inside payload")

endmodule

// ===== rtl/swfd_out_stage.sv =====
// result register with valid/ready toward the consumer
`include "assert_macros.svh"

module swfd_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  swfd_pkg::result_type  load_data,
   output logic                  space,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output swfd_pkg::result_type  rsp_data
);

   logic                 valid_ff, valid_in;
   swfd_pkg::result_type data_ff, data_in;

   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   `SWFD_ASSERT(a_no_overwrite, !(load && valid_ff && !rsp_ready),
      "result loaded over a beat still waiting")
   `SWFD_ASSERT_NEXT(a_load_shows, load, valid_ff, "loaded result not presented")

endmodule

// ===== rtl/sync_word_frame_deframer_core.sv =====
// top level of the sync word frame deframer: csr bank, input register, parser, result register
// throughput: one byte per cycle while the result register has space or is drained;
// req_ready is high when the input register is empty or drains
// reset: synchronous, active high; clears the parser state and valid flags, and loads the
// sync bytes 0x5A/0xA5 and the payload limit 1024
module sync_word_frame_deframer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [swfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [swfd_pkg::WORD_W-1:0]     csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [swfd_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_kind,
   output logic [swfd_pkg::WORD_W-1:0]     rsp_channel,
   output logic [swfd_pkg::BYTE_W-1:0]     rsp_payload_byte,
   output logic                            rsp_frame_last
);

   swfd_pkg::cfg_type             cfg_ff, cfg_in;
   logic                          in_valid_ff, in_valid_in;
   logic [swfd_pkg::BYTE_W-1:0]   in_byte_ff, in_byte_in;
   logic                          out_space;
   logic                          in_fire;
   logic                          res_valid;
   swfd_pkg::result_type          res;
   swfd_pkg::result_type          rsp_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            swfd_pkg::CSR_SYNC_FIRST:  cfg_in.sync_first  = csr_wdata[swfd_pkg::BYTE_W-1:0];
            swfd_pkg::CSR_SYNC_SECOND: cfg_in.sync_second = csr_wdata[swfd_pkg::BYTE_W-1:0];
            swfd_pkg::CSR_MAX_PAYLOAD: cfg_in.max_payload = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   assign in_fire   = in_valid_ff && out_space;
   assign req_ready = !in_valid_ff || out_space;

   always_comb begin
      in_valid_in = in_valid_ff && !out_space;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= swfd_pkg::SYNC_FIRST_RST;
         cfg_ff.sync_second <= swfd_pkg::SYNC_SECOND_RST;
         cfg_ff.max_payload <= swfd_pkg::MAX_PAYLOAD_RST;
         in_valid_ff        <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   swfd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .byte_valid (in_fire),
      .byte_data  (in_byte_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   swfd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .space     (out_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind         = rsp_data.kind;
   assign rsp_channel      = rsp_data.channel;
   assign rsp_payload_byte = rsp_data.payload_byte;
   assign rsp_frame_last   = rsp_data.frame_last;

endmodule

// ===== tb/tb.sv =====
// testbench for the sync word frame deframer: random byte streams checked against a predictor
`timescale 1ns / 100ps

module tb;

   localparam logic [swfd_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [swfd_pkg::CSR_IDX_W-1:0] csr_index = swfd_pkg::CSR_SYNC_FIRST;
   logic [swfd_pkg::WORD_W-1:0]    csr_wdata = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [swfd_pkg::BYTE_W-1:0]    req_rx_byte = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_kind;
   logic [swfd_pkg::WORD_W-1:0]    rsp_channel;
   logic [swfd_pkg::BYTE_W-1:0]    rsp_payload_byte;
   logic                           rsp_frame_last;

   sync_word_frame_deframer_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_channel      (rsp_channel),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_last   (rsp_frame_last)
   );

   always #5 clock = ~clock;

   // parser copy
   swfd_pkg::cfg_type            parser_cfg;
   logic [swfd_pkg::PHASE_W-1:0] parse_phase = swfd_pkg::PH_SYNC0;
   logic [swfd_pkg::HDR_W-1:0]   hdr_index = swfd_pkg::HDR_CHAN_LO;
   logic [swfd_pkg::WORD_W-1:0]  frame_chan = '0;
   logic [swfd_pkg::WORD_W-1:0]  frame_len = '0;
   logic [swfd_pkg::WORD_W-1:0]  payload_cnt = '0;

   swfd_pkg::result_type        expected_beats[$];
   swfd_pkg::result_type        want_beat;
   logic [swfd_pkg::BYTE_W-1:0] pending_bytes[$];
   int unsigned       queued_total = 0;
   int unsigned       accepted_total = 0;
   int unsigned       fail_count = 0;
   int unsigned       send_gap = 0;
   int unsigned       recv_stall = 0;
   bit                send_calm = 1'b0;
   bit                recv_calm = 1'b0;
   bit                req_taken = 1'b0;

   initial begin
      parser_cfg.sync_first  = swfd_pkg::SYNC_FIRST_RST;
      parser_cfg.sync_second = swfd_pkg::SYNC_SECOND_RST;
      parser_cfg.max_payload = swfd_pkg::MAX_PAYLOAD_RST;
   end

   task automatic predict_byte(input logic [swfd_pkg::BYTE_W-1:0] b);
      swfd_pkg::result_type          beat;
      logic [swfd_pkg::WORD_W:0]     next_cnt;
      case (parse_phase)
         swfd_pkg::PH_SYNC0: begin
            if (b == parser_cfg.sync_first) parse_phase = swfd_pkg::PH_SYNC1;
         end
         swfd_pkg::PH_SYNC1: begin
            if (b == parser_cfg.sync_second) begin
               hdr_index = swfd_pkg::HDR_CHAN_LO;
               parse_phase = swfd_pkg::PH_HEADER;
            end else if (b != parser_cfg.sync_first) begin
               parse_phase = swfd_pkg::PH_SYNC0;
            end
         end
         swfd_pkg::PH_HEADER: begin
            case (hdr_index)
               swfd_pkg::HDR_CHAN_LO: frame_chan[7:0] = b;
               swfd_pkg::HDR_CHAN_HI: frame_chan[15:8] = b;
               swfd_pkg::HDR_LEN_LO:  frame_len[7:0] = b;
               default:               frame_len[15:8] = b;
            endcase
            if (hdr_index == swfd_pkg::HDR_LEN_HI) begin
               if (frame_len == '0) begin
                  parse_phase = swfd_pkg::PH_SYNC0;
                  beat.kind = swfd_pkg::KIND_EMPTY;
                  beat.channel = frame_chan;
                  beat.payload_byte = '0;
                  beat.frame_last = 1'b1;
                  expected_beats = {expected_beats, beat};
               end else if (frame_len > parser_cfg.max_payload) begin
                  parse_phase = swfd_pkg::PH_SYNC0;
               end else begin
                  payload_cnt = '0;
                  parse_phase = swfd_pkg::PH_PAYLOAD;
               end
            end
            hdr_index = hdr_index + 2'd1;
         end
         default: begin
            next_cnt = {1'b0, payload_cnt} + 17'd1;
            beat.kind = swfd_pkg::KIND_PAYLOAD;
            beat.channel = frame_chan;
            beat.payload_byte = b;
            beat.frame_last = (next_cnt >= {1'b0, frame_len});
            payload_cnt = next_cnt[swfd_pkg::WORD_W-1:0];
            if (beat.frame_last) parse_phase = swfd_pkg::PH_SYNC0;
            expected_beats = {expected_beats, beat};
         end
      endcase
   endtask

   // accept and check beats
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            predict_byte(req_rx_byte);
            accepted_total++;
            if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
            send_gap = send_calm ? 0 : $urandom_range(0, 11);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected beat: kind %0d channel %0h byte %0h last %0d",
                      rsp_kind, rsp_channel, rsp_payload_byte, rsp_frame_last);
               fail_count++;
            end else begin
               want_beat = expected_beats.pop_front();
               if (rsp_kind !== want_beat.kind) begin
                  $error("kind: expected %0d, got %0d", want_beat.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_channel !== want_beat.channel) begin
                  $error("channel: expected %0h, got %0h", want_beat.channel, rsp_channel);
                  fail_count++;
               end
               if (rsp_payload_byte !== want_beat.payload_byte) begin
                  $error("payload_byte: expected %0h, got %0h",
                         want_beat.payload_byte, rsp_payload_byte);
                  fail_count++;
               end
               if (rsp_frame_last !== want_beat.frame_last) begin
                  $error("frame_last: expected %0d, got %0d",
                         want_beat.frame_last, rsp_frame_last);
                  fail_count++;
               end
            end
            if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
            recv_stall = recv_calm ? 0 : $urandom_range(0, 11);
         end
      end
   end

   // drive bytes and result backpressure
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_rx_byte <= pending_bytes.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic write_csr(input logic [swfd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [swfd_pkg::WORD_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         swfd_pkg::CSR_SYNC_FIRST:  parser_cfg.sync_first = data[swfd_pkg::BYTE_W-1:0];
         swfd_pkg::CSR_SYNC_SECOND: parser_cfg.sync_second = data[swfd_pkg::BYTE_W-1:0];
         swfd_pkg::CSR_MAX_PAYLOAD: parser_cfg.max_payload = data;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [swfd_pkg::BYTE_W-1:0] sf,
                             input logic [swfd_pkg::BYTE_W-1:0] ss,
                             input logic [swfd_pkg::WORD_W-1:0] mx);
      write_csr(swfd_pkg::CSR_SYNC_FIRST, {8'($urandom_range(0, 255)), sf});
      write_csr(swfd_pkg::CSR_SYNC_SECOND, {8'($urandom_range(0, 255)), ss});
      write_csr(swfd_pkg::CSR_MAX_PAYLOAD, mx);
   endtask

   task automatic queue_byte(input logic [swfd_pkg::BYTE_W-1:0] b);
      pending_bytes = {pending_bytes, b};
      queued_total++;
   endtask

   function automatic logic [swfd_pkg::WORD_W-1:0] pick_channel();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 16'h0000;
      if (sel == 1) return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic queue_frame(input logic [swfd_pkg::WORD_W-1:0] chan,
                              input logic [swfd_pkg::WORD_W-1:0] len,
                              input int unsigned extra_first);
      repeat (extra_first) queue_byte(parser_cfg.sync_first);
      queue_byte(parser_cfg.sync_first);
      queue_byte(parser_cfg.sync_second);
      queue_byte(chan[7:0]);
      queue_byte(chan[15:8]);
      queue_byte(len[7:0]);
      queue_byte(len[15:8]);
      if (len <= parser_cfg.max_payload)
         repeat (len) queue_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic queue_traffic(input int unsigned n_bytes);
      int unsigned      start;
      int unsigned      pick;
      int unsigned      lim;
      int unsigned      len;
      int unsigned      reps;
      logic [swfd_pkg::BYTE_W-1:0] b;
      start = queued_total;
      lim = parser_cfg.max_payload;
      while (queued_total - start < n_bytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            len = $urandom_range(0, (lim < 12) ? lim : 12);
            if (lim <= 64 && $urandom_range(0, 7) == 0) len = lim;
            else if ($urandom_range(0, 39) == 0) len = $urandom_range(0, (lim < 300) ? lim : 300);
            reps = 0;
            if (parser_cfg.sync_first != parser_cfg.sync_second && $urandom_range(0, 4) == 0)
               reps = $urandom_range(1, 3);
            queue_frame(pick_channel(), 16'(len), reps);
         end else if (pick < 75 && lim < 65535) begin
            len = $urandom_range(0, 1) ? lim + 1 : $urandom_range(lim + 1, 65535);
            queue_frame(pick_channel(), 16'(len), 0);
         end else if (pick < 85) begin
            if (lim <= 255 && $urandom_range(0, 1) == 1) begin
               queue_byte(parser_cfg.sync_first);
               queue_byte(parser_cfg.sync_second);
               repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
            end else begin
               do b = 8'($urandom_range(0, 255));
               while (b == parser_cfg.sync_first || b == parser_cfg.sync_second);
               queue_byte(parser_cfg.sync_first);
               queue_byte(b);
            end
         end else begin
            repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic wait_drained();
      while (accepted_total != queued_total || expected_beats.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [swfd_pkg::BYTE_W-1:0] sf;
      logic [swfd_pkg::BYTE_W-1:0] ss;
      logic [swfd_pkg::WORD_W-1:0] mx;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // repeated first sync, all-ones channel, one byte
      queue_frame(16'hFFFF, 16'd1, 1);
      // broken sync pair, then an empty frame
      queue_byte(swfd_pkg::SYNC_FIRST_RST);
      queue_byte(8'h00);
      queue_frame(16'h0000, 16'd0, 0);
      // one past the limit
      queue_frame(16'h1234, swfd_pkg::MAX_PAYLOAD_RST + 16'd1, 0);
      wait_drained();
      write_csr(CSR_SPARE, 16'hFFFF);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               sf = swfd_pkg::SYNC_FIRST_RST;
               ss = swfd_pkg::SYNC_SECOND_RST;
               mx = swfd_pkg::MAX_PAYLOAD_RST;
            end
            1: begin
               sf = 8'h00; ss = 8'hFF; mx = 16'hFFFF;
            end
            2: begin
               sf = 8'($urandom_range(0, 255)); ss = sf; mx = 16'd0;
            end
            3: begin
               sf = 8'hFF; ss = 8'h00; mx = 16'd8;
            end
            default: begin
               sf = 8'($urandom_range(0, 255));
               ss = ($urandom_range(0, 5) == 0) ? sf : 8'($urandom_range(0, 255));
               case ($urandom_range(0, 2))
                  0: mx = 16'($urandom_range(0, 40));
                  1: mx = 16'($urandom_range(0, 300));
                  default: mx = 16'hFFFF;
               endcase
            end
         endcase
         if (p != 0) set_config(sf, ss, mx);
         queue_traffic(160);
         wait_drained();
      end

      repeat (8) @(negedge clock);
      if (fail_count == 0 && expected_beats.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
